// File: hdl/rut_pkg.sv
// ----------------------------------------------------------------------------
// Recency usage table package
// Shared widths, codes, reset values and payload types for the recency
// usage table core and its entry store.
// ----------------------------------------------------------------------------
`default_nettype none

package rut_pkg;

	// Default table depth.
	localparam int ENTRIES_DEF = 16;

	// Field widths.
	localparam int ACT_W  = 2;
	localparam int KEY_W  = 32;
	localparam int TURN_W = 32;
	localparam int COOL_W = 8;
	localparam int CNT_W  = 16;
	localparam int PEN_W  = 23;

	// Configuration port widths.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_RECORD  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_PENALTY = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RECENT  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_DECAY   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_COUNT_STEP     = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_HARD_WINDOW    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SOFT_WINDOW    = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SOFT_SLOPE     = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_HARD_SURCHARGE = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_DECAY_PERIOD   = 3'd5;

	// Register reset values.
	localparam logic [7:0]  COUNT_STEP_RST     = 8'd80;
	localparam logic [7:0]  HARD_WINDOW_RST    = 8'd12;
	localparam logic [7:0]  SOFT_WINDOW_RST    = 8'd24;
	localparam logic [7:0]  SOFT_SLOPE_RST     = 8'd60;
	localparam logic [15:0] HARD_SURCHARGE_RST = 16'd5000;
	localparam logic [7:0]  DECAY_PERIOD_RST   = 8'd20;

	// Arithmetic limits.
	localparam logic [PEN_W-1:0] PENALTY_BASE = 23'd100;
	localparam logic [PEN_W-1:0] PENALTY_MAX  = 23'h7FFFFF;
	localparam logic [CNT_W-1:0] COUNT_MAX    = 16'hFFFF;

	// Input transaction payload.
	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [KEY_W-1:0]  phrase_key;
		logic [TURN_W-1:0] current_turn;
		logic [COOL_W-1:0] cooldown;
	} rut_in_t;

	// Output transaction payload.
	typedef struct packed {
		logic [PEN_W-1:0] penalty_pct;
		logic             recently_used;
		logic             found;
	} rut_out_t;

	// One table entry.
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [CNT_W-1:0]  count;
		logic [TURN_W-1:0] stamp;
	} entry_t;

endpackage

`default_nettype wire

// File: hdl/rut_table.sv
// ----------------------------------------------------------------------------
// Recency usage table entry store
// One write port and one registered read port over the entry memory, with a
// valid bit per entry so that an entry never written reads as all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rut_table
	import rut_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   wr_en,
	input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
	input  wire entry_t                                 wr_entry,
	input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
	output entry_t                                      rd_entry
);

	entry_t               mem_q [ENTRIES];
	logic [ENTRIES-1:0]   vld_q;
	entry_t               rd_data_s1;
	logic                 rd_vld_s1;

	// Entry memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		rd_data_s1 <= mem_q[rd_addr];
	end

	// Valid bits stand in for clearing the memory at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_s1 <= vld_q[rd_addr];
		end
	end

	// An entry that was never written reads as its reset value of zero.
	assign rd_entry = rd_vld_s1 ? rd_data_s1 : '0;

endmodule

`default_nettype wire

// File: hdl/recency_usage_table_core.sv
// ----------------------------------------------------------------------------
// Recency usage table core
// A table of usage entries (key, saturating use count, last turn) with
// record, penalty query, recent query and decay operations, run by a small
// sequencer over one shared age subtractor and a bit-serial divider.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                          | Direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_ready, in_data      | input
//   out     | out_valid, out_ready, out_data   | output
//   cfg     | cfg_we, cfg_addr, cfg_wdata      | input
//
// The entry scan for record and the queries reads one entry per cycle from
// the single memory read port. Decay divides only for an entry that loses
// counts, with the divider resolving one quotient bit per cycle.
// Reset clears every entry at once through per-entry valid bits; no sweep.
// A new transaction is taken only in idle; a finished result may still wait
// in the output register, and the sequencer stalls only to load the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module recency_usage_table_core
	import rut_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire rut_in_t               in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output rut_out_t                   out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_SCAN  = 13'b0000000000010,
		S_DRAIN = 13'b0000000000100,
		S_REC   = 13'b0000000001000,
		S_AGE   = 13'b0000000010000,
		S_MUL   = 13'b0000000100000,
		S_SUM   = 13'b0000001000000,
		S_DRD   = 13'b0000010000000,
		S_DLAT  = 13'b0000100000000,
		S_DCHK  = 13'b0001000000000,
		S_DDIV  = 13'b0010000000000,
		S_DWR   = 13'b0100000000000,
		S_OUT   = 13'b1000000000000
	} state_t;

	state_t               state_q;
	rut_in_t              in_q;
	logic [IDX_W-1:0]     idx_q;

	// Configuration registers.
	logic [7:0]           count_step_q;
	logic [7:0]           hard_window_q;
	logic [7:0]           soft_window_q;
	logic [7:0]           soft_slope_q;
	logic [15:0]          hard_surcharge_q;
	logic [7:0]           decay_period_q;

	// Scan pipeline and accumulators.
	logic                 proc_s1;
	logic [IDX_W-1:0]     idx_s1;
	entry_t               rd_entry;
	logic                 match_found_q;
	logic [IDX_W-1:0]     match_idx_q;
	logic [CNT_W-1:0]     match_cnt_q;
	logic [TURN_W-1:0]    match_turn_q;
	logic                 empty_found_q;
	logic [IDX_W-1:0]     empty_idx_q;
	logic [IDX_W-1:0]     lru_idx_q;
	logic [TURN_W-1:0]    lru_turn_q;
	logic                 recent_found_q;
	logic [TURN_W-1:0]    recent_turn_q;

	// Arithmetic datapath.
	logic [TURN_W-1:0]    turn_sel;
	logic [TURN_W-1:0]    age_now;
	logic [TURN_W-1:0]    age_q;
	logic [CNT_W+7:0]     prod_q;
	logic [15:0]          sur_q;
	logic [PEN_W:0]       pen_sum;
	logic [PEN_W-1:0]     pen_q;
	logic                 rec_q;
	entry_t               ent_q;
	logic [7:0]           div_rem_q;
	logic [TURN_W-1:0]    div_quot_q;
	logic [4:0]           div_cnt_q;
	logic [8:0]           div_trial;
	logic                 div_ge;

	// Table write port.
	logic                 tbl_we;
	logic [IDX_W-1:0]     tbl_waddr;
	entry_t               tbl_wentry;
	logic [IDX_W-1:0]     rec_idx;
	logic [CNT_W-1:0]     rec_base;
	logic [CNT_W-1:0]     dec_cnt;

	logic                 in_fire;
	logic                 out_load;
	rut_out_t             out_q;
	logic                 out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	rut_table #(
		.ENTRIES (ENTRIES)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (tbl_we),
		.wr_addr  (tbl_waddr),
		.wr_entry (tbl_wentry),
		.rd_addr  (idx_q),
		.rd_entry (rd_entry)
	);

	// Shared age unit: decay uses the entry just read, queries the found entry.
	always_comb begin
		if (state_q == S_DLAT) begin
			turn_sel = rd_entry.stamp;
		end else if (in_q.action == ACT_RECENT) begin
			turn_sel = recent_turn_q;
		end else begin
			turn_sel = match_turn_q;
		end
		age_now = (in_q.current_turn > turn_sel) ? (in_q.current_turn - turn_sel) : '0;
	end

	// Penalty sum of base, per-use step and age surcharge.
	assign pen_sum = (PEN_W+1)'(PENALTY_BASE) + (PEN_W+1)'(prod_q) + (PEN_W+1)'(sur_q);

	// Divider step: one quotient bit per cycle.
	assign div_trial = {div_rem_q, div_quot_q[TURN_W-1]};
	assign div_ge    = (div_trial >= {1'b0, decay_period_q});

	// Record target and table write selection.
	always_comb begin
		rec_idx  = match_found_q ? match_idx_q : (empty_found_q ? empty_idx_q : lru_idx_q);
		rec_base = match_found_q ? match_cnt_q : '0;
		dec_cnt  = (div_quot_q >= TURN_W'(ent_q.count)) ? '0 :
		           (ent_q.count - div_quot_q[CNT_W-1:0]);
		tbl_we   = 1'b0;
		tbl_waddr  = idx_q;
		tbl_wentry = '0;
		case (state_q)
			S_REC: begin
				tbl_we               = 1'b1;
				tbl_waddr            = rec_idx;
				tbl_wentry.key       = in_q.phrase_key;
				tbl_wentry.count     = (rec_base == COUNT_MAX) ? COUNT_MAX : rec_base + 1'b1;
				tbl_wentry.stamp     = in_q.current_turn;
			end
			S_DWR: begin
				tbl_we               = 1'b1;
				tbl_waddr            = idx_q;
				tbl_wentry.key       = ent_q.key;
				tbl_wentry.count     = dec_cnt;
				tbl_wentry.stamp     = in_q.current_turn;
			end
			default: begin
				tbl_we = 1'b0;
			end
		endcase
	end

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_step_q     <= COUNT_STEP_RST;
			hard_window_q    <= HARD_WINDOW_RST;
			soft_window_q    <= SOFT_WINDOW_RST;
			soft_slope_q     <= SOFT_SLOPE_RST;
			hard_surcharge_q <= HARD_SURCHARGE_RST;
			decay_period_q   <= DECAY_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_COUNT_STEP:     count_step_q     <= cfg_wdata[7:0];
				REG_HARD_WINDOW:    hard_window_q    <= cfg_wdata[7:0];
				REG_SOFT_WINDOW:    soft_window_q    <= cfg_wdata[7:0];
				REG_SOFT_SLOPE:     soft_slope_q     <= cfg_wdata[7:0];
				REG_HARD_SURCHARGE: hard_surcharge_q <= cfg_wdata;
				REG_DECAY_PERIOD:   decay_period_q   <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			proc_s1     <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			proc_s1 <= (state_q == S_SCAN);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						idx_q <= '0;
						if (in_data.action != ACT_DECAY) begin
							state_q <= S_SCAN;
						end else if (decay_period_q != '0) begin
							state_q <= S_DRD;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_SCAN: begin
					if (idx_q == IDX_LAST) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= (in_q.action == ACT_RECORD) ? S_REC : S_AGE;
				end
				S_REC: begin
					state_q <= S_OUT;
				end
				S_AGE: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= (in_q.action == ACT_PENALTY) ? S_SUM : S_OUT;
				end
				S_SUM: begin
					state_q <= S_OUT;
				end
				S_DRD: begin
					state_q <= S_DLAT;
				end
				S_DLAT: begin
					state_q <= S_DCHK;
				end
				S_DCHK: begin
					if ((ent_q.count == '0) || (age_q < TURN_W'(decay_period_q))) begin
						if (idx_q == IDX_LAST) begin
							state_q <= S_OUT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_DRD;
						end
					end else begin
						div_cnt_q <= 5'd31;
						state_q   <= S_DDIV;
					end
				end
				S_DDIV: begin
					if (div_cnt_q == '0) begin
						state_q <= S_DWR;
					end else begin
						div_cnt_q <= div_cnt_q - 1'b1;
					end
				end
				S_DWR: begin
					if (idx_q == IDX_LAST) begin
						state_q <= S_OUT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_DRD;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Scan accumulators, arithmetic and result payload.
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (in_fire) begin
			in_q           <= in_data;
			match_found_q  <= 1'b0;
			empty_found_q  <= 1'b0;
			recent_found_q <= 1'b0;
			pen_q          <= '0;
			rec_q          <= 1'b0;
		end

		// One entry per cycle: first match, first empty, least recent.
		if (proc_s1) begin
			if (!match_found_q && (rd_entry.key == in_q.phrase_key)) begin
				match_found_q <= 1'b1;
				match_idx_q   <= idx_s1;
				match_cnt_q   <= rd_entry.count;
				match_turn_q  <= rd_entry.stamp;
			end
			if (!empty_found_q && (rd_entry.count == '0)) begin
				empty_found_q <= 1'b1;
				empty_idx_q   <= idx_s1;
			end
			if ((idx_s1 == '0) || (rd_entry.stamp < lru_turn_q)) begin
				lru_idx_q  <= idx_s1;
				lru_turn_q <= rd_entry.stamp;
			end
			if (!recent_found_q && (rd_entry.key == in_q.phrase_key) &&
			    (rd_entry.count != '0)) begin
				recent_found_q <= 1'b1;
				recent_turn_q  <= rd_entry.stamp;
			end
		end

		if ((state_q == S_AGE) || (state_q == S_DLAT)) begin
			age_q <= age_now;
		end
		if (state_q == S_DLAT) begin
			ent_q <= rd_entry;
		end

		// Products and recent test, registered before the sum.
		if (state_q == S_MUL) begin
			prod_q <= (CNT_W+8)'(match_cnt_q) * (CNT_W+8)'(count_step_q);
			if (age_q < TURN_W'(hard_window_q)) begin
				sur_q <= hard_surcharge_q;
			end else if (age_q < TURN_W'(soft_window_q)) begin
				sur_q <= 16'(soft_window_q - age_q[7:0]) * 16'(soft_slope_q);
			end else begin
				sur_q <= '0;
			end
			rec_q <= (in_q.action == ACT_RECENT) && recent_found_q &&
			         (age_q < TURN_W'(in_q.cooldown));
		end

		if (state_q == S_SUM) begin
			if (!match_found_q) begin
				pen_q <= PENALTY_BASE;
			end else if (pen_sum > (PEN_W+1)'(PENALTY_MAX)) begin
				pen_q <= PENALTY_MAX;
			end else begin
				pen_q <= pen_sum[PEN_W-1:0];
			end
		end

		// Restoring division of the age by the decay period.
		if (state_q == S_DCHK) begin
			div_rem_q  <= '0;
			div_quot_q <= age_q;
		end else if (state_q == S_DDIV) begin
			div_rem_q  <= div_ge ? 8'(div_trial - {1'b0, decay_period_q}) : div_trial[7:0];
			div_quot_q <= {div_quot_q[TURN_W-2:0], div_ge};
		end

		if (out_load) begin
			out_q.penalty_pct   <= pen_q;
			out_q.recently_used <= rec_q;
			out_q.found         <= match_found_q;
		end
	end

`ifndef SYNTHESIS
	// The block is busy right after taking a transaction.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("in_ready high right after an accepted transaction");

	// The table is written only by a record or a decay write step.
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> ((state_q == S_REC) || (state_q == S_DWR)))
		else $error("table write outside record or decay write");

	// A decay write always removes at least one count.
	a_decay_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DWR) |-> (div_quot_q != '0))
		else $error("decay write with a zero drop");

	// A new result appears only out of the result state.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result raised outside the result state");
`endif

endmodule

`default_nettype wire
